FILE: design/sorted_triple_group_aggregator_top_defines.svh
// Assertion macros for the sorted triple group aggregator.
`ifndef SORTED_TRIPLE_GROUP_AGGREGATOR_TOP_DEFINES_SVH
`define SORTED_TRIPLE_GROUP_AGGREGATOR_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define STGAGG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define STGAGG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/stgagg_pkg.sv
// Types, constants and helpers shared by the sorted triple group aggregator.
package stgagg_pkg;

  localparam int KEY_W    = 32;
  localparam int CNT_W    = 32;
  localparam int ORDER_W  = 3;
  localparam int MAX_RECS = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    REC_PAIR   = 2'd0,
    REC_KEY    = 2'd1,
    REC_TOTALS = 2'd2
  } rec_kind_e;

  typedef enum logic {
    ITEM_TRIPLE = 1'b0,
    ITEM_END    = 1'b1
  } item_kind_e;

  typedef struct packed {
    rec_kind_e        kind;
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] second_key;
    logic [CNT_W-1:0] run_count;
    logic [CNT_W-1:0] key_groups;
    logic [CNT_W-1:0] pair_groups;
    logic [CNT_W-1:0] distinct_triples;
    logic             last;
  } rec_t;

  typedef struct packed {
    logic                 en;
    logic [1:0]           n_rec;
    rec_t [MAX_RECS-1:0]  rec;
  } push_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

FILE: design/stgagg_ifs.sv
// Valid/ready channel interfaces for input items and result items.
interface stgagg_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [stgagg_pkg::KEY_W-1:0] first_key;
  logic [stgagg_pkg::KEY_W-1:0] second_key;
  logic [stgagg_pkg::KEY_W-1:0] third_key;

  modport source (output valid, kind, first_key, second_key, third_key, input ready);
  modport sink (input valid, kind, first_key, second_key, third_key, output ready);
endinterface

interface stgagg_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   record_kind;
  logic [stgagg_pkg::KEY_W-1:0] out_first_key;
  logic [stgagg_pkg::KEY_W-1:0] out_second_key;
  logic [stgagg_pkg::CNT_W-1:0] run_count;
  logic [stgagg_pkg::CNT_W-1:0] key_groups;
  logic [stgagg_pkg::CNT_W-1:0] pair_groups;
  logic [stgagg_pkg::CNT_W-1:0] distinct_triples;
  logic                         last;

  modport source (output valid, record_kind, out_first_key, out_second_key, run_count,
                  key_groups, pair_groups, distinct_triples, last, input ready);
  modport sink (input valid, record_kind, out_first_key, out_second_key, run_count,
                key_groups, pair_groups, distinct_triples, last, output ready);
endinterface

FILE: design/stgagg_core.sv
// Input register, run and total state, and result record generation.
module stgagg_core (
  input  logic                           clk,
  input  logic                           rst_n,
  stgagg_in_if.sink                      in_item,
  input  logic                           cfg_we,
  input  logic [stgagg_pkg::ORDER_W-1:0] cfg_wdata,
  input  logic                           room,
  output stgagg_pkg::push_t              push
);

  logic                           item_v_r;
  logic                           kind_r;
  logic [stgagg_pkg::KEY_W-1:0]   a_r, b_r, c_r;
  logic [stgagg_pkg::ORDER_W-1:0] index_order_r;

  logic                         have_prev_r, have_prev_nxt;
  logic [stgagg_pkg::KEY_W-1:0] prev_first_r, prev_first_nxt;
  logic [stgagg_pkg::KEY_W-1:0] prev_second_r, prev_second_nxt;
  logic [stgagg_pkg::KEY_W-1:0] prev_third_r, prev_third_nxt;
  logic [stgagg_pkg::CNT_W-1:0] pair_run_r, pair_run_nxt;
  logic [stgagg_pkg::CNT_W-1:0] key_run_r, key_run_nxt;
  logic [stgagg_pkg::CNT_W-1:0] tot_keys_r, tot_keys_nxt;
  logic [stgagg_pkg::CNT_W-1:0] tot_pairs_r, tot_pairs_nxt;
  logic [stgagg_pkg::CNT_W-1:0] tot_triples_r, tot_triples_nxt;

  logic is_end, first_chg, second_chg, close_pair, close_key, take;
  stgagg_pkg::rec_t pair_rec, key_rec, tot_rec;

  assign take          = item_v_r && room;
  assign in_item.ready = !item_v_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r      <= 1'b0;
      index_order_r <= '0;
    end else begin
      if (in_item.ready) begin
        item_v_r <= in_item.valid;
      end
      if (cfg_we) begin
        index_order_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      kind_r <= in_item.kind;
      a_r    <= in_item.first_key;
      b_r    <= in_item.second_key;
      c_r    <= in_item.third_key;
    end
  end

  assign is_end     = (kind_r == stgagg_pkg::ITEM_END);
  assign first_chg  = (a_r != prev_first_r);
  assign second_chg = (b_r != prev_second_r);
  assign close_pair = have_prev_r && (is_end || first_chg || second_chg);
  assign close_key  = have_prev_r && (is_end || first_chg) && !index_order_r[0];

  always_comb begin
    pair_rec            = '0;
    pair_rec.kind       = stgagg_pkg::REC_PAIR;
    pair_rec.first_key  = prev_first_r;
    pair_rec.second_key = prev_second_r;
    pair_rec.run_count  = pair_run_r;

    key_rec           = '0;
    key_rec.kind      = stgagg_pkg::REC_KEY;
    key_rec.first_key = prev_first_r;
    key_rec.run_count = key_run_r;

    tot_rec                  = '0;
    tot_rec.kind             = stgagg_pkg::REC_TOTALS;
    tot_rec.key_groups       = tot_keys_r;
    tot_rec.pair_groups      = tot_pairs_r;
    tot_rec.distinct_triples = tot_triples_r;
    tot_rec.last             = 1'b1;
  end

  always_comb begin
    push.en     = take;
    push.n_rec  = 2'(close_pair) + 2'(close_key) + 2'(is_end);
    push.rec[0] = close_pair ? pair_rec : tot_rec;
    push.rec[1] = close_key ? key_rec : tot_rec;
    push.rec[2] = tot_rec;
  end

  always_comb begin
    have_prev_nxt   = have_prev_r;
    prev_first_nxt  = prev_first_r;
    prev_second_nxt = prev_second_r;
    prev_third_nxt  = prev_third_r;
    pair_run_nxt    = pair_run_r;
    key_run_nxt     = key_run_r;
    tot_keys_nxt    = tot_keys_r;
    tot_pairs_nxt   = tot_pairs_r;
    tot_triples_nxt = tot_triples_r;
    if (take) begin
      if (is_end) begin
        have_prev_nxt   = 1'b0;
        prev_first_nxt  = '0;
        prev_second_nxt = '0;
        prev_third_nxt  = '0;
        pair_run_nxt    = '0;
        key_run_nxt     = '0;
        tot_keys_nxt    = '0;
        tot_pairs_nxt   = '0;
        tot_triples_nxt = '0;
      end else begin
        prev_first_nxt  = a_r;
        prev_second_nxt = b_r;
        prev_third_nxt  = c_r;
        if (!have_prev_r) begin
          have_prev_nxt   = 1'b1;
          pair_run_nxt    = stgagg_pkg::CNT_W'(1);
          key_run_nxt     = stgagg_pkg::CNT_W'(1);
          tot_keys_nxt    = stgagg_pkg::CNT_W'(1);
          tot_pairs_nxt   = stgagg_pkg::CNT_W'(1);
          tot_triples_nxt = stgagg_pkg::CNT_W'(1);
        end else if (first_chg) begin
          pair_run_nxt    = stgagg_pkg::CNT_W'(1);
          key_run_nxt     = stgagg_pkg::CNT_W'(1);
          tot_keys_nxt    = stgagg_pkg::sat_inc(tot_keys_r);
          tot_pairs_nxt   = stgagg_pkg::sat_inc(tot_pairs_r);
          tot_triples_nxt = stgagg_pkg::sat_inc(tot_triples_r);
        end else if (second_chg) begin
          pair_run_nxt    = stgagg_pkg::CNT_W'(1);
          key_run_nxt     = stgagg_pkg::sat_inc(key_run_r);
          tot_pairs_nxt   = stgagg_pkg::sat_inc(tot_pairs_r);
          tot_triples_nxt = stgagg_pkg::sat_inc(tot_triples_r);
        end else begin
          pair_run_nxt = stgagg_pkg::sat_inc(pair_run_r);
          key_run_nxt  = stgagg_pkg::sat_inc(key_run_r);
          if (c_r != prev_third_r) begin
            tot_triples_nxt = stgagg_pkg::sat_inc(tot_triples_r);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r   <= 1'b0;
      prev_first_r  <= '0;
      prev_second_r <= '0;
      prev_third_r  <= '0;
      pair_run_r    <= '0;
      key_run_r     <= '0;
      tot_keys_r    <= '0;
      tot_pairs_r   <= '0;
      tot_triples_r <= '0;
    end else begin
      have_prev_r   <= have_prev_nxt;
      prev_first_r  <= prev_first_nxt;
      prev_second_r <= prev_second_nxt;
      prev_third_r  <= prev_third_nxt;
      pair_run_r    <= pair_run_nxt;
      key_run_r     <= key_run_nxt;
      tot_keys_r    <= tot_keys_nxt;
      tot_pairs_r   <= tot_pairs_nxt;
      tot_triples_r <= tot_triples_nxt;
    end
  end

endmodule

FILE: design/stgagg_outq.sv
// Shifting result queue that takes up to three records a cycle and sends one while the output is ready.
module stgagg_outq #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  stgagg_pkg::push_t push,
  output logic              room,
  stgagg_out_if.source      out_item
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  stgagg_pkg::rec_t q_r [DEPTH];
  stgagg_pkg::rec_t q_nxt [DEPTH];
  logic [CW-1:0]    count_r, count_nxt;
  logic [SW-1:0]    base;
  logic             pop;

  assign pop  = out_item.valid && out_item.ready;
  assign base = SW'(count_r) - SW'(pop);
  assign room = (base + SW'(push.n_rec)) <= SW'(DEPTH);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      q_nxt[i] = q_r[i];
      if (pop && (i < DEPTH - 1)) begin
        q_nxt[i] = q_r[(i + 1) % DEPTH];
      end
      for (int j = 0; j < stgagg_pkg::MAX_RECS; j++) begin
        if (push.en && (SW'(j) < SW'(push.n_rec)) && (base + SW'(j) == SW'(i))) begin
          q_nxt[i] = push.rec[j];
        end
      end
    end
    count_nxt = CW'(base + (push.en ? SW'(push.n_rec) : SW'(0)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_item.valid            = (count_r != '0);
  assign out_item.record_kind      = q_r[0].kind;
  assign out_item.out_first_key    = q_r[0].first_key;
  assign out_item.out_second_key   = q_r[0].second_key;
  assign out_item.run_count        = q_r[0].run_count;
  assign out_item.key_groups       = q_r[0].key_groups;
  assign out_item.pair_groups      = q_r[0].pair_groups;
  assign out_item.distinct_triples = q_r[0].distinct_triples;
  assign out_item.last             = q_r[0].last;

endmodule

FILE: design/sorted_triple_group_aggregator_top.sv
// Sorted triple group aggregator: one pass over a sorted stream of triples that
// emits a record for each closed pair run, a record for each closed first-key run
// when the index order is even, and a totals record marked last on each end item.
// An item is held in an input register until the result queue has room for its records. The
// block accepts one item per cycle as long as the QUEUE_DEPTH-entry result queue
// (at least three) has room for every record the held item produces; the result
// side sends one record per cycle while the receiver is ready, so a stream in which
// items close runs is paced by the number of records it yields. The index order
// may be written only while idle.
module sorted_triple_group_aggregator_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  stgagg_in_if.sink                      in_item,
  stgagg_out_if.source                   out_item,
  input  logic                           cfg_we,
  input  logic [stgagg_pkg::ORDER_W-1:0] cfg_wdata
);

  `include "sorted_triple_group_aggregator_top_defines.svh"

  stgagg_pkg::push_t push;
  logic              room;

  stgagg_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .room      (room),
    .push      (push)
  );

  stgagg_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_item (out_item)
  );

  `STGAGG_ASSERT_SAME(a_no_push_without_room, !room, !push.en, "item taken without queue room")
  `STGAGG_ASSERT_SAME(a_last_is_totals,
    out_item.valid && out_item.last,
    out_item.record_kind == stgagg_pkg::REC_TOTALS,
    "last set on a run record")
  `STGAGG_ASSERT_SAME(a_run_nonzero,
    out_item.valid && (out_item.record_kind != stgagg_pkg::REC_TOTALS),
    out_item.run_count != '0,
    "run record with zero count")
  `STGAGG_ASSERT_NEXT(a_end_yields_result,
    push.en && (push.n_rec != 2'd0),
    out_item.valid,
    "pushed records not visible")

endmodule
